/* rtl/core/xeue_pkg.sv */
package xeue_pkg;

  localparam int QueueDepthDefault = 4;

  localparam logic [15:0] OneByteMax = 16'h007F;
  localparam logic [15:0] TwoByteMax = 16'h07FF;

  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Cont  = 8'h80;
  localparam logic [5:0] Low6  = 6'h3F;

  typedef enum logic [2:0] {
    KIND_UTF1,
    KIND_UTF2,
    KIND_UTF3,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_QUOT,
    KIND_APOS
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  len;
    logic [15:0] cp;
  } desc_t;

  function automatic logic [2:0] kind_len(input kind_t kind);
    logic [2:0] n;
    unique case (kind)
      KIND_UTF1:             n = 3'd1;
      KIND_UTF2:             n = 3'd2;
      KIND_UTF3:             n = 3'd3;
      KIND_LT, KIND_GT:      n = 3'd4;
      KIND_AMP:              n = 3'd5;
      KIND_QUOT, KIND_APOS:  n = 3'd6;
      default:               n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] entity_char(input kind_t kind, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h3B;
    if (idx == 3'd0) begin
      c = 8'h26;
    end else begin
      unique case (kind)
        KIND_AMP: begin
          case (idx)
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h6D;
            3'd3:    c = 8'h70;
            default: c = 8'h3B;
          endcase
        end
        KIND_LT: begin
          case (idx)
            3'd1:    c = 8'h6C;
            3'd2:    c = 8'h74;
            default: c = 8'h3B;
          endcase
        end
        KIND_GT: begin
          case (idx)
            3'd1:    c = 8'h67;
            3'd2:    c = 8'h74;
            default: c = 8'h3B;
          endcase
        end
        KIND_QUOT: begin
          case (idx)
            3'd1:    c = 8'h71;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h6F;
            3'd4:    c = 8'h74;
            default: c = 8'h3B;
          endcase
        end
        KIND_APOS: begin
          case (idx)
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h70;
            3'd3:    c = 8'h6F;
            3'd4:    c = 8'h73;
            default: c = 8'h3B;
          endcase
        end
        default: c = 8'h3B;
      endcase
    end
    return c;
  endfunction

  function automatic logic [7:0] unit_byte(input desc_t d, input logic [2:0] idx);
    logic [7:0] b;
    unique case (d.kind)
      KIND_UTF1: b = d.cp[7:0];
      KIND_UTF2: b = (idx == 3'd0) ? (Lead2 | {3'b000, d.cp[10:6]})
                                   : (Cont | {2'b00, d.cp[5:0] & Low6});
      KIND_UTF3: begin
        case (idx)
          3'd0:    b = Lead3 | {4'h0, d.cp[15:12]};
          3'd1:    b = Cont | {2'b00, d.cp[11:6] & Low6};
          default: b = Cont | {2'b00, d.cp[5:0] & Low6};
        endcase
      end
      default:   b = entity_char(d.kind, idx);
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/xeue_front.sv */
module xeue_front import xeue_pkg::*; (
  input  logic [15:0] code_point,
  output desc_t       desc
);

  kind_t kind;

  always_comb begin
    unique case (code_point)
      16'h0026: kind = KIND_AMP;
      16'h003C: kind = KIND_LT;
      16'h003E: kind = KIND_GT;
      16'h0022: kind = KIND_QUOT;
      16'h0027: kind = KIND_APOS;
      default: begin
        if (code_point <= OneByteMax) begin
          kind = KIND_UTF1;
        end else if (code_point <= TwoByteMax) begin
          kind = KIND_UTF2;
        end else begin
          kind = KIND_UTF3;
        end
      end
    endcase
  end

  assign desc.kind = kind;
  assign desc.len  = kind_len(kind);
  assign desc.cp   = code_point;

endmodule

/* rtl/core/xeue_queue.sv */
module xeue_queue import xeue_pkg::*; #(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  input  logic  pop,
  output desc_t head,
  output logic  empty,
  output logic  full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  desc_t           slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == FullCnt);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

/* rtl/core/xeue_back.sv */
module xeue_back import xeue_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  desc_t      head,
  input  logic       empty,
  output logic       pop,
  output logic       valid,
  output logic [7:0] out_byte,
  output logic       last
);

  logic [2:0] idx;
  logic [2:0] idx_next;
  logic       final_byte;

  assign final_byte = (idx == head.len - 3'd1);
  assign pop        = !empty && final_byte;

  always_comb begin
    idx_next = idx;
    if (!empty) begin
      idx_next = final_byte ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= 3'd0;
      valid <= 1'b0;
    end else begin
      idx   <= idx_next;
      valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    out_byte <= unit_byte(head, idx);
    last     <= final_byte;
  end

endmodule

/* rtl/core/xml_escape_utf8_encoder_core.sv */
// Escapes and UTF-8 encodes one 16-bit code point per start transfer, emitting one byte per
// cycle on out_byte while any character is queued, with valid high on each byte and last on
// the final byte of each character; the receiver cannot stall. A character yields 1 to 3
// UTF-8 bytes or a 4 to 6 byte entity, all sent before the next character's bytes, and its
// first byte goes through a queue slot and then the output register. Characters are classified
// on entry and held in a small queue of QUEUE_DEPTH entries; busy is high only while that queue
// is full, so sustained throughput is set by the byte sequencer at one output byte per cycle.
module xml_escape_utf8_encoder_core import xeue_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] code_point,
  output logic        valid,
  output logic [7:0]  out_byte,
  output logic        last
);

  desc_t desc;
  desc_t head;
  logic  empty;
  logic  full;
  logic  pop;
  logic  push;

  assign busy = full;
  assign push = start && !full;

  xeue_front u_front (
    .code_point (code_point),
    .desc       (desc)
  );

  xeue_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (desc),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  xeue_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .valid    (valid),
    .out_byte (out_byte),
    .last     (last)
  );

endmodule

/* tb/tb_xml_escape_utf8_encoder_core.sv */
`timescale 1ns / 1ps

module tb_xml_escape_utf8_encoder_core;
  import xeue_pkg::*;

  localparam int CycleLimit = 100000;

  localparam logic [15:0] CharAmp  = 16'h0026;
  localparam logic [15:0] CharLt   = 16'h003C;
  localparam logic [15:0] CharGt   = 16'h003E;
  localparam logic [15:0] CharQuot = 16'h0022;
  localparam logic [15:0] CharApos = 16'h0027;

  typedef struct {
    logic [7:0] data;
    logic       final_byte;
  } out_byte_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] code_point;
  logic        valid;
  logic [7:0]  out_byte;
  logic        last;

  out_byte_t expected_bytes[$];
  int        errors;
  int        cycles;
  int        chars_sent;
  int        escapes_sent;
  int        bytes_checked;
  bit        idle_enabled;

  xml_escape_utf8_encoder_core DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .code_point (code_point),
    .valid      (valid),
    .out_byte   (out_byte),
    .last       (last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("xml_escape_utf8_encoder_core: mismatch");
      $finish;
    end
  end

  // classify the character, then queue its escaped utf-8 byte sequence
  task automatic predict_encoding(input logic [15:0] cp);
    kind_t      kind;
    string      ent;
    logic [7:0] seq[$];
    out_byte_t  ob;
    case (cp)
      CharAmp:  kind = KIND_AMP;
      CharLt:   kind = KIND_LT;
      CharGt:   kind = KIND_GT;
      CharQuot: kind = KIND_QUOT;
      CharApos: kind = KIND_APOS;
      default: begin
        if (cp <= OneByteMax) kind = KIND_UTF1;
        else if (cp <= TwoByteMax) kind = KIND_UTF2;
        else kind = KIND_UTF3;
      end
    endcase
    ent = "";
    case (kind)
      KIND_UTF1: seq.push_back(cp[7:0]);
      KIND_UTF2: begin
        seq.push_back(Lead2 | {3'b000, cp[10:6]});
        seq.push_back(Cont | {2'b00, cp[5:0]});
      end
      KIND_UTF3: begin
        seq.push_back(Lead3 | {4'h0, cp[15:12]});
        seq.push_back(Cont | {2'b00, cp[11:6]});
        seq.push_back(Cont | {2'b00, cp[5:0]});
      end
      KIND_AMP:  ent = "&amp;";
      KIND_LT:   ent = "&lt;";
      KIND_GT:   ent = "&gt;";
      KIND_QUOT: ent = "&quot;";
      default:   ent = "&apos;";
    endcase
    if (ent.len() != 0) escapes_sent++;
    for (int i = 0; i < ent.len(); i++) seq.push_back(ent[i]);
    foreach (seq[i]) begin
      ob.data = seq[i];
      ob.final_byte = (i == seq.size() - 1);
      expected_bytes.push_back(ob);
    end
  endtask

  task automatic send_char(input logic [15:0] cp);
    @(negedge clk);
    start <= 1'b1;
    code_point <= cp;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_encoding(cp);
    chars_sent++;
  endtask

  task automatic maybe_idle();
    if (idle_enabled && $urandom_range(99) < 14) begin
      @(negedge clk);
      start <= 1'b0;
      code_point <= 16'($urandom);
      repeat ($urandom_range(3)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] random_code_point();
    logic [15:0] cp;
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(4))
          0:       cp = CharAmp;
          1:       cp = CharLt;
          2:       cp = CharGt;
          3:       cp = CharQuot;
          default: cp = CharApos;
        endcase
      end
      2, 3: cp = 16'($urandom_range(OneByteMax));
      4, 5: cp = 16'($urandom_range(TwoByteMax, OneByteMax + 1));
      6, 7: cp = 16'($urandom_range(16'hFFFF, TwoByteMax + 1));
      default: cp = 16'($urandom);
    endcase
    return cp;
  endfunction

  always @(posedge clk) begin
    if (!rst && valid) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: out_byte actual %02h, last actual %0b", out_byte, last);
        errors++;
      end else begin
        if (out_byte !== expected_bytes[0].data) begin
          $error("out_byte: expected %02h, actual %02h", expected_bytes[0].data, out_byte);
          errors++;
        end
        if (last !== expected_bytes[0].final_byte) begin
          $error("last: expected %0b, actual %0b", expected_bytes[0].final_byte, last);
          errors++;
        end
        void'(expected_bytes.pop_front());
        bytes_checked++;
      end
    end
  end

  task automatic test_entities();
    send_char(CharAmp);
    send_char(CharLt);
    send_char(CharGt);
    send_char(CharQuot);
    send_char(CharApos);
    // neighbors of the escaped characters pass through unchanged
    send_char(16'h0025);
    send_char(16'h0028);
    send_char(16'h003D);
    send_char(16'h003B);
  endtask

  task automatic test_length_boundaries();
    send_char(16'h0041);
    send_char(OneByteMax);
    send_char(OneByteMax + 16'd1);
    send_char(16'h0100);
    send_char(TwoByteMax);
    send_char(TwoByteMax + 16'd1);
    send_char(16'h1234);
    send_char(16'h5555);
    send_char(16'hAAAA);
    send_char(16'hFFFE);
    send_char(16'hFFFF);
  endtask

  task automatic test_special_values();
    // zero is a plain byte, surrogates take the three-byte form
    send_char(16'h0000);
    send_char(16'hD800);
    send_char(16'hDFFF);
    wait_drained();
  endtask

  task automatic test_random_with_gaps();
    idle_enabled = 1'b1;
    for (int i = 0; i < 90; i++) begin
      send_char(random_code_point());
      maybe_idle();
      if (i == 45) wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    idle_enabled = 1'b0;
    for (int i = 0; i < 60; i++) send_char(random_code_point());
    // escapes in a row keep the queue full
    for (int i = 0; i < 10; i++) send_char(CharQuot);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    code_point = '0;
    errors = 0;
    cycles = 0;
    chars_sent = 0;
    escapes_sent = 0;
    bytes_checked = 0;
    idle_enabled = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_entities();
    test_length_boundaries();
    test_special_values();
    test_random_with_gaps();
    test_back_to_back();

    wait_drained();
    repeat (10) @(posedge clk);

    $display("sent %0d characters (%0d escaped), checked %0d output bytes", chars_sent,
             escapes_sent, bytes_checked);
    $display("covered entities, 1/2/3-byte boundaries, zero, surrogates, gaps and bursts");
    if (errors == 0) begin
      $display("xml_escape_utf8_encoder_core: match");
    end else begin
      $display("xml_escape_utf8_encoder_core: mismatch");
    end
    $finish;
  end

endmodule
